// ===== rtl/prmt_pkg.sv =====
// ----------------------------------------------------------------------------
// prmt_pkg
// shared types and codes for the page reverse map table
// ----------------------------------------------------------------------------
package prmt_pkg;

  localparam int unsigned PAGE_W   = 12;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned STATUS_W = 2;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // what a slot scan is looking for
  typedef enum logic [1:0] {
    SCAN_FREE  = 2'd0,
    SCAN_MATCH = 2'd1,
    SCAN_USED  = 2'd2
  } scan_mode_e;

  // controller to datapath
  typedef struct packed {
    logic       clr;
    logic       accept;
    logic       rd;
    logic       scan_init;
    logic       scan;
    scan_mode_e mode;
    logic       upd;
    logic       load_out;
    status_e    status;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic page_bad;
    logic is_rm;
    logic hit;
    logic miss;
    logic leaves_one;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/prmt_dp.sv =====
// ----------------------------------------------------------------------------
// prmt_dp
// datapath: slot memories, count memory, slot scanner and result register
// ----------------------------------------------------------------------------
module prmt_dp #(
  parameter int unsigned NUM_PAGES      = 256,
  parameter int unsigned SLOTS_PER_PAGE = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  prmt_pkg::dp_ctl_t               ctl_i,
  output prmt_pkg::dp_sts_t               sts_o,
  input  logic                            cmd_i,
  input  logic [prmt_pkg::PAGE_W-1:0]     page_i,
  input  logic [prmt_pkg::HANDLE_W-1:0]   handle_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [47:0]                     m_tdata_o
);

  localparam int unsigned DEPTH = NUM_PAGES * SLOTS_PER_PAGE;
  localparam int unsigned PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned SW    = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
  localparam int unsigned CW    = $clog2(SLOTS_PER_PAGE + 1);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW  = prmt_pkg::CNT_W;
  localparam int unsigned HW    = prmt_pkg::HANDLE_W;

  // storage
  logic [SLOTS_PER_PAGE-1:0] used_mem [NUM_PAGES];
  logic [CNTW-1:0]           cnt_mem  [NUM_PAGES];
  logic [HW-1:0]             hdl_mem  [DEPTH];

  // operation registers
  logic            cmd_q;
  logic [PW-1:0]   page_q;
  logic            range_q;
  logic [HW-1:0]   handle_q;
  logic [AW-1:0]   base_q;

  logic [SLOTS_PER_PAGE-1:0] row_rd_q, row_q;
  logic [CNTW-1:0]           cnt_rd_q, cnt_q;
  logic [HW-1:0]             hdl_rd_q;

  logic [PW-1:0]   clr_idx_q;
  logic [CW-1:0]   idx_q;
  logic            cmp_v_q;
  logic [SW-1:0]   cmp_idx_q;
  logic [SW-1:0]   hit_idx_q;
  logic            grant_q;
  logic [HW-1:0]   grant_hdl_q;

  logic            m_tvalid_q;
  logic [47:0]     m_tdata_q;

  logic                      page_bad;
  logic                      issuing;
  logic                      used_bit;
  logic                      cond;
  logic                      hit;
  logic                      miss;
  logic                      used_we;
  logic [PW-1:0]             used_wa;
  logic [SLOTS_PER_PAGE-1:0] used_wd;
  logic [CNTW-1:0]           cnt_wd;
  logic [SLOTS_PER_PAGE-1:0] row_new;
  logic [CNTW-1:0]           cnt_new;
  logic                      hdl_we;
  logic [AW-1:0]             hdl_wa;
  logic [AW-1:0]             hdl_ra;
  logic [CNTW-1:0]           ref_out;
  logic [HW-1:0]             hdl_out;

  assign page_bad = ({1'b0, page_i} >= (prmt_pkg::PAGE_W + 1)'(NUM_PAGES));

  // scanner compare stage
  assign issuing  = ctl_i.scan && (idx_q != CW'(SLOTS_PER_PAGE));
  assign used_bit = row_q[cmp_idx_q];

  always_comb begin
    case (ctl_i.mode)
      prmt_pkg::SCAN_FREE:  cond = !used_bit;
      prmt_pkg::SCAN_MATCH: cond = used_bit && (hdl_rd_q == handle_q);
      prmt_pkg::SCAN_USED:  cond = used_bit;
      default:              cond = 1'b0;
    endcase
  end

  assign hit  = cmp_v_q && cond;
  assign miss = cmp_v_q && !cond && (cmp_idx_q == SW'(SLOTS_PER_PAGE - 1));

  // slot update
  always_comb begin
    row_new            = row_q;
    row_new[hit_idx_q] = (cmd_q == prmt_pkg::CMD_ADD);
    cnt_new            = (cmd_q == prmt_pkg::CMD_ADD) ? cnt_q + CNTW'(1) : cnt_q - CNTW'(1);
  end

  always_comb begin
    used_we = ctl_i.clr || ctl_i.upd;
    used_wa = ctl_i.clr ? clr_idx_q : page_q;
    used_wd = ctl_i.clr ? '0 : row_new;
    cnt_wd  = ctl_i.clr ? '0 : cnt_new;
  end

  assign hdl_we = ctl_i.upd && (cmd_q == prmt_pkg::CMD_ADD);
  assign hdl_wa = base_q + AW'(hit_idx_q);
  assign hdl_ra = base_q + AW'(idx_q);

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
      cnt_mem[used_wa]  <= cnt_wd;
    end
    if (ctl_i.rd) begin
      row_rd_q <= used_mem[page_q];
      cnt_rd_q <= cnt_mem[page_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdl_we) begin
      hdl_mem[hdl_wa] <= handle_q;
    end
    if (issuing) begin
      hdl_rd_q <= hdl_mem[hdl_ra];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q    <= cmd_i;
      page_q   <= page_i[PW-1:0];
      range_q  <= page_bad;
      handle_q <= handle_i;
      base_q   <= AW'(32'(page_i) * 32'(SLOTS_PER_PAGE));
    end
    if (ctl_i.scan_init && !ctl_i.upd) begin
      row_q <= row_rd_q;
      cnt_q <= cnt_rd_q;
    end else if (ctl_i.upd) begin
      row_q <= row_new;
      cnt_q <= cnt_new;
    end
    if (issuing) begin
      cmp_idx_q <= idx_q[SW-1:0];
    end
    if (ctl_i.scan && hit) begin
      hit_idx_q   <= cmp_idx_q;
      grant_hdl_q <= hdl_rd_q;
    end
    if (ctl_i.load_out) begin
      m_tdata_q <= {6'd0, hdl_out, grant_q, ref_out, ctl_i.status};
    end
  end

  assign ref_out = range_q ? '0 : cnt_q;
  assign hdl_out = grant_q ? grant_hdl_q : '0;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      idx_q      <= '0;
      cmp_v_q    <= 1'b0;
      grant_q    <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        clr_idx_q <= clr_idx_q + PW'(1);
      end
      if (ctl_i.scan_init) begin
        idx_q   <= '0;
        cmp_v_q <= 1'b0;
      end else begin
        if (issuing) begin
          idx_q <= idx_q + CW'(1);
        end
        cmp_v_q <= issuing;
      end
      if (ctl_i.accept) begin
        grant_q <= 1'b0;
      end else if (ctl_i.scan && (ctl_i.mode == prmt_pkg::SCAN_USED) && hit) begin
        grant_q <= 1'b1;
      end
      if (ctl_i.load_out) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

  always_comb begin
    sts_o.clr_last   = (clr_idx_q == PW'(NUM_PAGES - 1));
    sts_o.page_bad   = page_bad;
    sts_o.is_rm      = (cmd_q == prmt_pkg::CMD_REMOVE);
    sts_o.hit        = hit;
    sts_o.miss       = miss;
    sts_o.leaves_one = (cmd_q == prmt_pkg::CMD_REMOVE) && (cnt_q == CNTW'(2));
    sts_o.out_free   = !m_tvalid_q || m_tready_i;
  end

endmodule

// ===== rtl/prmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// prmt_ctrl
// controller: clearing pass, operation sequencing and result hand-off
// ----------------------------------------------------------------------------
module prmt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  prmt_pkg::dp_sts_t sts_i,
  output prmt_pkg::dp_ctl_t ctl_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_LD,
    S_SCAN,
    S_UPD,
    S_GRANT,
    S_FIN
  } state_e;

  state_e            state_q;
  prmt_pkg::status_e status_q;
  logic              accept;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      status_q <= prmt_pkg::ST_OK;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (sts_i.page_bad) begin
              status_q <= prmt_pkg::ST_RANGE;
              state_q  <= S_FIN;
            end else begin
              status_q <= prmt_pkg::ST_OK;
              state_q  <= S_RD;
            end
          end
        end
        S_RD: state_q <= S_LD;
        S_LD: state_q <= S_SCAN;
        S_SCAN: begin
          if (sts_i.hit) begin
            state_q <= S_UPD;
          end else if (sts_i.miss) begin
            status_q <= sts_i.is_rm ? prmt_pkg::ST_NOT_FOUND : prmt_pkg::ST_FULL;
            state_q  <= S_FIN;
          end
        end
        S_UPD: state_q <= sts_i.leaves_one ? S_GRANT : S_FIN;
        S_GRANT: begin
          if (sts_i.hit || sts_i.miss) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl_o           = '0;
    ctl_o.status    = status_q;
    ctl_o.accept    = accept;
    ctl_o.clr       = (state_q == S_CLEAR);
    ctl_o.rd        = (state_q == S_RD);
    ctl_o.scan_init = (state_q == S_LD) || (state_q == S_UPD);
    ctl_o.scan      = (state_q == S_SCAN) || (state_q == S_GRANT);
    ctl_o.upd       = (state_q == S_UPD);
    ctl_o.load_out  = (state_q == S_FIN) && sts_i.out_free;
    if (state_q == S_GRANT) begin
      ctl_o.mode = prmt_pkg::SCAN_USED;
    end else if (sts_i.is_rm) begin
      ctl_o.mode = prmt_pkg::SCAN_MATCH;
    end else begin
      ctl_o.mode = prmt_pkg::SCAN_FREE;
    end
  end

endmodule

// ===== rtl/page_reverse_map_table.sv =====
// ----------------------------------------------------------------------------
// page_reverse_map_table
// per-page reverse map of pte handles with reference counts
// ----------------------------------------------------------------------------
// operation: an add or a plain remove scans the page's slots once before the
//   result valid rises; a remove that leaves one mapping adds a second scan for
//   the remaining mapping; an out-of-range page skips the scan
// throughput: one operation at a time, next transfer accepted in the cycle after the result
//   is loaded, set by the one-slot-per-cycle scan of the handle memory read port
// reset: after rst_ni a clearing pass zeroes the used marks and counts of every
//   page, one page per cycle, with s_axis_tready held low
// ----------------------------------------------------------------------------
module page_reverse_map_table #(
  parameter int unsigned NUM_PAGES      = 256,
  parameter int unsigned SLOTS_PER_PAGE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // operation in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // page_number[11:0], pte_handle[43:12], zero pad
  input  logic        s_axis_tuser,   // cmd: 0 add mapping, 1 remove mapping
  // result out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // status[1:0], ref_after[8:2], grant_write[9],
                                      // grant_handle[41:10], zero pad
);

  prmt_pkg::dp_ctl_t ctl;
  prmt_pkg::dp_sts_t sts;

  // sequencing: clear pass, read page row, scan slots, write back, grant scan
  prmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // memories, scanner and the result register that decouples the output side
  prmt_dp #(
    .NUM_PAGES      (NUM_PAGES),
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .cmd_i      (s_axis_tuser),
    .page_i     (s_axis_tdata[11:0]),
    .handle_i   (s_axis_tdata[43:12]),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule
